FILE: hw/rtl/cmps_pkg.sv
// Shared types and constants for the chain-mail pattern shader.
// Used by cmps_scale, cmps_ring and chain_mail_pattern_shader; depends on nothing.

package cmps_pkg;

    // Default fractional precision of the cell coordinate.
    localparam int FRAC_BITS_DEF = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONNECTING = 3'd4;

    // Register reset values.
    localparam logic [7:0]  RST_REPEAT     = 8'd1;
    localparam logic [31:0] RST_BACKGROUND = 32'h0000_00FF;
    localparam logic [31:0] RST_CENTER     = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_CONNECTING = 32'h8080_80FF;

    // Mask level codes.
    typedef enum logic [1:0] {
        MASK_NONE   = 2'd0,
        MASK_CONN   = 2'd1,
        MASK_CENTER = 2'd2
    } t_mask_level;

    // Per-stage load enables of the pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_pipe_en;

endpackage

FILE: hw/rtl/chain_mail_pattern_shader.sv
// Chain-mail pattern shader: five-stage pipeline, one pixel per cycle unless stalled.
// An accepted input transaction passes through stage registers s1 to s5 to a valid result.
// Throughput is one transaction per cycle while the output is not stalled; each stage
// loads when it is empty or its successor loads, so bubbles close up during an output stall.
// Synchronous active-low reset clears the valid bits and restores the config registers.
// Depends on cmps_pkg, cmps_scale and cmps_ring.

module chain_mail_pattern_shader #(
    parameter int FRAC_BITS = cmps_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [cmps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Pixel coordinate stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [15:0] coord_u, [31:16] coord_v
    // Pixel result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // [31:0] pixel_color, [33:32] mask_level, rest 0
);

    // Configuration registers; writes are always taken.
    logic [7:0]  r_repeat_x;
    logic [7:0]  r_repeat_y;
    logic [31:0] r_background;
    logic [31:0] r_center;
    logic [31:0] r_connecting;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_x   <= cmps_pkg::RST_REPEAT;
            r_repeat_y   <= cmps_pkg::RST_REPEAT;
            r_background <= cmps_pkg::RST_BACKGROUND;
            r_center     <= cmps_pkg::RST_CENTER;
            r_connecting <= cmps_pkg::RST_CONNECTING;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cmps_pkg::REG_REPEAT_X:   r_repeat_x   <= i_cfg_data[7:0];
                cmps_pkg::REG_REPEAT_Y:   r_repeat_y   <= i_cfg_data[7:0];
                cmps_pkg::REG_BACKGROUND: r_background <= i_cfg_data;
                cmps_pkg::REG_CENTER:     r_center     <= i_cfg_data;
                cmps_pkg::REG_CONNECTING: r_connecting <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage valid bits and load enables.
    logic [5:1]         r_vld;
    cmps_pkg::t_pipe_en w_en;

    assign w_en.s5 = !r_vld[5] || i_m_axis_tready;
    assign w_en.s4 = !r_vld[4] || w_en.s5;
    assign w_en.s3 = !r_vld[3] || w_en.s4;
    assign w_en.s2 = !r_vld[2] || w_en.s3;
    assign w_en.s1 = !r_vld[1] || w_en.s2;

    assign o_s_axis_tready = w_en.s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en.s1) r_vld[1] <= i_s_axis_tvalid;
            if (w_en.s2) r_vld[2] <= r_vld[1];
            if (w_en.s3) r_vld[3] <= r_vld[2];
            if (w_en.s4) r_vld[4] <= r_vld[3];
            if (w_en.s5) r_vld[5] <= r_vld[4];
        end
    end

    // Scaling, folding and ring offsets.
    logic [FRAC_BITS-1:0] w_cen_xm;
    logic [FRAC_BITS:0]   w_cen_xp;
    logic [FRAC_BITS-1:0] w_cen_ym;
    logic [FRAC_BITS:0]   w_cen_yp;
    logic [FRAC_BITS-1:0] w_con_xm;
    logic [FRAC_BITS:0]   w_con_xp;
    logic [FRAC_BITS-1:0] w_con_ym;
    logic [FRAC_BITS:0]   w_con_yp;
    logic                 w_center_first;

    cmps_scale #(
        .FRAC_BITS(FRAC_BITS)
    ) u_scale (
        .i_clk          (i_clk),
        .i_en           (w_en),
        .i_coord_u      (i_s_axis_tdata[15:0]),
        .i_coord_v      (i_s_axis_tdata[31:16]),
        .i_repeat_x     (r_repeat_x),
        .i_repeat_y     (r_repeat_y),
        .o_cen_xm       (w_cen_xm),
        .o_cen_xp       (w_cen_xp),
        .o_cen_ym       (w_cen_ym),
        .o_cen_yp       (w_cen_yp),
        .o_con_xm       (w_con_xm),
        .o_con_xp       (w_con_xp),
        .o_con_ym       (w_con_ym),
        .o_con_yp       (w_con_yp),
        .o_center_first (w_center_first)
    );

    // Band tests for the center ring and the connecting ring.
    logic w_center_hit;
    logic w_conn_hit;

    cmps_ring #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ring_center (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_xm  (w_cen_xm),
        .i_xp  (w_cen_xp),
        .i_ym  (w_cen_ym),
        .i_yp  (w_cen_yp),
        .o_hit (w_center_hit)
    );

    cmps_ring #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ring_conn (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_xm  (w_con_xm),
        .i_xp  (w_con_xp),
        .i_ym  (w_con_ym),
        .i_yp  (w_con_yp),
        .o_hit (w_conn_hit)
    );

    // Carry the priority flag alongside the ring tests.
    logic r_pri_3;
    logic r_pri_4;

    always_ff @(posedge i_clk) begin
        if (w_en.s3) r_pri_3 <= w_center_first;
        if (w_en.s4) r_pri_4 <= r_pri_3;
    end

    // Stage 5: priority select of color and mask level.
    cmps_pkg::t_mask_level w_level;
    logic [31:0]           w_color;
    cmps_pkg::t_mask_level r_level;
    logic [31:0]           r_color;

    always_comb begin
        w_level = cmps_pkg::MASK_NONE;
        w_color = r_background;
        if (r_pri_4) begin
            if (w_center_hit) begin
                w_level = cmps_pkg::MASK_CENTER;
                w_color = r_center;
            end else if (w_conn_hit) begin
                w_level = cmps_pkg::MASK_CONN;
                w_color = r_connecting;
            end
        end else begin
            if (w_conn_hit) begin
                w_level = cmps_pkg::MASK_CONN;
                w_color = r_connecting;
            end else if (w_center_hit) begin
                w_level = cmps_pkg::MASK_CENTER;
                w_color = r_center;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en.s5) begin
            r_level <= w_level;
            r_color <= w_color;
        end
    end

    assign o_m_axis_tvalid = r_vld[5];
    assign o_m_axis_tdata  = {6'd0, r_level, r_color};

    // An empty output stage must never hold off the input side.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while output stage is empty");

    // A delivered result never carries the unused mask code.
    a_level_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[33:32] == cmps_pkg::MASK_NONE)
                         || (o_m_axis_tdata[33:32] == cmps_pkg::MASK_CONN)
                         || (o_m_axis_tdata[33:32] == cmps_pkg::MASK_CENTER))
        else $error("illegal mask level on output");

    // A full pipeline with a stalled output accepts nothing new.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld == 5'b11111) && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input accepted into a full stalled pipeline");

endmodule

FILE: hw/rtl/cmps_scale.sv
// Stages 1 and 2: scale the coordinate by the repeat counts, form the cell
// and half-shifted cell positions, fold them, build the ring offsets and the priority flag.
// Depends on cmps_pkg.

module cmps_scale #(
    parameter int FRAC_BITS = cmps_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  cmps_pkg::t_pipe_en   i_en,
    input  logic [15:0]          i_coord_u,
    input  logic [15:0]          i_coord_v,
    input  logic [7:0]           i_repeat_x,
    input  logic [7:0]           i_repeat_y,
    output logic [FRAC_BITS-1:0] o_cen_xm,
    output logic [FRAC_BITS:0]   o_cen_xp,
    output logic [FRAC_BITS-1:0] o_cen_ym,
    output logic [FRAC_BITS:0]   o_cen_yp,
    output logic [FRAC_BITS-1:0] o_con_xm,
    output logic [FRAC_BITS:0]   o_con_xp,
    output logic [FRAC_BITS-1:0] o_con_ym,
    output logic [FRAC_BITS:0]   o_con_yp,
    output logic                 o_center_first
);

    localparam logic [FRAC_BITS-1:0] HALF_Q = {1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam int PW = FRAC_BITS + 8;

    // Fold a position above one half back into the lower half of the cell.
    function automatic logic [FRAC_BITS-1:0] fold(input logic [FRAC_BITS-1:0] v);
        fold = (v > HALF_Q) ? ('0 - v) : v;
    endfunction

    logic [FRAC_BITS-1:0] w_qu;
    logic [FRAC_BITS-1:0] w_qv;
    logic [FRAC_BITS+7:0] w_pu;
    logic [FRAC_BITS+7:0] w_pv;

    // Bring the Q0.16 input to the working precision.
    if (FRAC_BITS >= 16) begin : g_widen
        assign w_qu = FRAC_BITS'(i_coord_u) << (FRAC_BITS - 16);
        assign w_qv = FRAC_BITS'(i_coord_v) << (FRAC_BITS - 16);
    end else begin : g_narrow
        assign w_qu = FRAC_BITS'(i_coord_u >> (16 - FRAC_BITS));
        assign w_qv = FRAC_BITS'(i_coord_v >> (16 - FRAC_BITS));
    end

    assign w_pu = PW'(w_qu) * PW'(i_repeat_x);
    assign w_pv = PW'(w_qv) * PW'(i_repeat_y);

    // Stage 1: keep only the fraction of the scaled coordinate.
    logic [FRAC_BITS-1:0] r_x;
    logic [FRAC_BITS-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_x <= w_pu[FRAC_BITS-1:0];
            r_y <= w_pv[FRAC_BITS-1:0];
        end
    end

    // Stage 2 logic: half-cell shift, diagonal flip and fold.
    logic [FRAC_BITS-1:0] w_xc;
    logic [FRAC_BITS-1:0] w_yc;
    logic [FRAC_BITS:0]   w_sum;
    logic                 w_flip;
    logic                 w_flipt;
    logic [FRAC_BITS-1:0] w_fx;
    logic [FRAC_BITS-1:0] w_fy;
    logic [FRAC_BITS-1:0] w_fxc;
    logic [FRAC_BITS-1:0] w_fyc;

    assign w_xc    = r_x + HALF_Q;
    assign w_yc    = r_y + HALF_Q;
    assign w_sum   = {1'b0, r_x} + {1'b0, r_y};
    assign w_flip  = r_y > r_x;
    assign w_flipt = w_sum[FRAC_BITS] && (w_sum[FRAC_BITS-1:0] != '0);
    assign w_fx    = fold(r_x);
    assign w_fy    = fold(r_y);
    assign w_fxc   = fold(w_xc);
    assign w_fyc   = fold(w_yc);

    // Stage 2: offsets from the folded positions to the ring centers.
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            o_cen_xm       <= HALF_Q - w_fx;
            o_cen_xp       <= {1'b0, HALF_Q} + {1'b0, w_fx};
            o_cen_ym       <= HALF_Q - w_fy;
            o_cen_yp       <= {1'b0, HALF_Q} + {1'b0, w_fy};
            o_con_xm       <= HALF_Q - w_fxc;
            o_con_xp       <= {1'b0, HALF_Q} + {1'b0, w_fxc};
            o_con_ym       <= HALF_Q - w_fyc;
            o_con_yp       <= {1'b0, HALF_Q} + {1'b0, w_fyc};
            o_center_first <= w_flip ^ w_flipt;
        end
    end

endmodule

FILE: hw/rtl/cmps_ring.sv
// Stages 3 and 4: square the ring offsets, then test the three squared
// distances against the ring band. Depends on cmps_pkg.

module cmps_ring #(
    parameter int FRAC_BITS = cmps_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  cmps_pkg::t_pipe_en   i_en,
    input  logic [FRAC_BITS-1:0] i_xm,
    input  logic [FRAC_BITS:0]   i_xp,
    input  logic [FRAC_BITS-1:0] i_ym,
    input  logic [FRAC_BITS:0]   i_yp,
    output logic                 o_hit
);

    localparam int SW = 2 * FRAC_BITS + 2;
    localparam int MW = 2 * FRAC_BITS;
    localparam logic [63:0] RM_Q = ((64'd39 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [63:0] RP_Q = ((64'd55 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [SW-1:0] RM_SQ = SW'(RM_Q * RM_Q);
    localparam logic [SW-1:0] RP_SQ = SW'(RP_Q * RP_Q);

    // Stage 3: exact squares of each offset.
    logic [2*FRAC_BITS-1:0] r_sq_xm;
    logic [2*FRAC_BITS-1:0] r_sq_ym;
    logic [SW-1:0]          r_sq_xp;
    logic [SW-1:0]          r_sq_yp;

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_sq_xm <= MW'(i_xm) * MW'(i_xm);
            r_sq_ym <= MW'(i_ym) * MW'(i_ym);
            r_sq_xp <= SW'(i_xp) * SW'(i_xp);
            r_sq_yp <= SW'(i_yp) * SW'(i_yp);
        end
    end

    // Stage 4: squared distances to the three ring centers and band test.
    logic [SW-1:0] w_d_mm;
    logic [SW-1:0] w_d_mp;
    logic [SW-1:0] w_d_pm;
    logic          w_hit;

    assign w_d_mm = SW'(r_sq_xm) + SW'(r_sq_ym);
    assign w_d_mp = SW'(r_sq_xm) + r_sq_yp;
    assign w_d_pm = r_sq_xp + SW'(r_sq_ym);
    assign w_hit  = ((w_d_mm >= RM_SQ) && (w_d_mm <= RP_SQ))
                 || ((w_d_mp >= RM_SQ) && (w_d_mp <= RP_SQ))
                 || ((w_d_pm >= RM_SQ) && (w_d_pm <= RP_SQ));

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            o_hit <= w_hit;
        end
    end

endmodule
